>>> rtl/spq_pkg.sv
// spq_pkg: shared opcodes, status codes, default sizes and the
// controller/datapath command and status structs of the sorted priority queue
// no dependencies
package spq_pkg;

    // opcodes of an input beat
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    // status codes of a result beat
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int SCORE_W          = 32;
    localparam int TAG_W            = 32;

    // commands from controller to datapath
    typedef struct packed {
        logic       ins;       // insert the input entry in order
        logic       pop;       // drop the head, shift up
        logic       rot;       // rotate the occupied cells by one
        logic       emit;      // drive a result beat next cycle
        logic       use_head;  // result carries the head entry
        logic [1:0] status;
        logic       last;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_stat;

endpackage

>>> rtl/spq_ctrl.sv
// spq_ctrl: controller of the sorted priority queue, decodes commands and
// sequences the list walk
// depends on spq_pkg
module spq_ctrl import spq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [1:0]    i_opcode,
    input  t_stat         i_stat,
    input  logic [CW-1:0] i_count,
    output logic          busy,
    output t_cmd          o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic          r_state, n_state;
    logic [CW-1:0] r_left, n_left;

    assign busy = (r_state == S_LIST);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_opcode)
                        OP_INSERT: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.ins    = 1'b1;
                                o_cmd.status = ST_OK;
                            end
                        end
                        OP_REMOVE: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.use_head = 1'b1;
                                o_cmd.status   = ST_OK;
                            end
                        end
                        OP_LIST: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                                o_cmd.last   = 1'b1;
                            end else begin
                                // first beat goes out right away
                                o_cmd.rot      = 1'b1;
                                o_cmd.use_head = 1'b1;
                                o_cmd.status   = ST_OK;
                                o_cmd.last     = (i_count == CW'(1));
                                n_left         = i_count - CW'(1);
                                if (i_count != CW'(1)) begin
                                    n_state = S_LIST;
                                end
                            end
                        end
                        default: begin
                            // unused opcode, no result
                        end
                    endcase
                end
            end
            S_LIST: begin
                o_cmd.emit     = 1'b1;
                o_cmd.rot      = 1'b1;
                o_cmd.use_head = 1'b1;
                o_cmd.status   = ST_OK;
                o_cmd.last     = (r_left == CW'(1));
                n_left         = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

endmodule

>>> rtl/spq_dp.sv
// spq_dp: datapath of the sorted priority queue, a row of entry cells with
// per-cell compare and shift, the fill count and the result registers
// depends on spq_pkg
module spq_dp import spq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    localparam int CW      = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [TAG_W-1:0]          i_tag,
    output t_stat                     o_stat,
    output logic [CW-1:0]             o_count,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic signed [SCORE_W-1:0] o_out_score,
    output logic [TAG_W-1:0]          o_out_tag,
    output logic                      o_last
);

    logic signed [SCORE_W-1:0] r_score [CAPACITY];
    logic [TAG_W-1:0]          r_tag   [CAPACITY];
    logic signed [SCORE_W-1:0] n_score [CAPACITY];
    logic [TAG_W-1:0]          n_tag   [CAPACITY];
    logic [CW-1:0]             r_count, n_count;
    logic [CAPACITY-1:0]       stay;

    logic                      r_valid;
    logic [1:0]                r_status;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [TAG_W-1:0]          r_out_tag;
    logic                      r_last;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(CAPACITY));
    assign o_count      = r_count;

    // cells that keep their entry on insert: head keeps on ties,
    // later cells keep only on a strictly greater score
    always_comb begin
        stay[0] = (r_count != '0) && (r_score[0] >= i_score);
        for (int i = 1; i < CAPACITY; i++) begin
            stay[i] = (CW'(i) < r_count) && (r_score[i] > i_score);
        end
    end

    // next cell contents
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_score[i] = r_score[i];
            n_tag[i]   = r_tag[i];
        end
        if (i_cmd.ins) begin
            n_count = r_count + CW'(1);
            if (!stay[0]) begin
                n_score[0] = i_score;
                n_tag[0]   = i_tag;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!stay[i]) begin
                    if (stay[i-1]) begin
                        n_score[i] = i_score;
                        n_tag[i]   = i_tag;
                    end else begin
                        n_score[i] = r_score[i-1];
                        n_tag[i]   = r_tag[i-1];
                    end
                end
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_score[i] = r_score[i+1];
                n_tag[i]   = r_tag[i+1];
            end
        end else if (i_cmd.rot) begin
            // head wraps to the tail slot, the rest move up
            for (int i = 0; i < CAPACITY - 1; i++) begin
                n_score[i] = r_score[i+1];
                n_tag[i]   = r_tag[i+1];
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i) == r_count - CW'(1)) begin
                    n_score[i] = r_score[0];
                    n_tag[i]   = r_tag[0];
                end
            end
        end
    end

    // entry cells, no reset needed
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            r_score[i] <= n_score[i];
            r_tag[i]   <= n_tag[i];
        end
    end

    // fill count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status    <= i_cmd.status;
            r_last      <= i_cmd.last;
            r_out_score <= i_cmd.use_head ? r_score[0] : '0;
            r_out_tag   <= i_cmd.use_head ? r_tag[0] : '0;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_score = r_out_score;
    assign o_out_tag   = r_out_tag;
    assign o_last      = r_last;

endmodule

>>> rtl/sorted_priority_queue.sv
// sorted_priority_queue: top level, bounded max-priority queue kept in
// descending score order; joins spq_ctrl and spq_dp, depends on spq_pkg
//
// Usage:
//   A command beat is taken on a rising edge with start high and busy low:
//   i_opcode selects insert (i_score, i_tag), remove highest, or list all.
//   Unused opcodes are ignored and give no result.
//   Each result beat shows on o_status, o_out_score, o_out_tag, o_last for
//   exactly one cycle with o_valid high; the receiver cannot stall it.
//   Insert and remove: one result beat in the cycle after the command, and
//   a new command may follow on the very next edge; the insert position is
//   found by a compare in every cell at once.
//   List: one beat per stored entry on consecutive cycles, starting the
//   cycle after the command; busy stays high while the cell row rotates
//   once around.
//   An empty list or remove gives one beat with status empty; an insert
//   into a full queue is dropped and gives status full.
//   Reset (synchronous, active low) empties the queue and drops any list
//   in progress; entry contents are not cleared.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [TAG_W-1:0]          i_tag,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic signed [SCORE_W-1:0] o_out_score,
    output logic [TAG_W-1:0]          o_out_tag,
    output logic                      o_last
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_cmd          cmd;
    t_stat         stat;
    logic [CW-1:0] count;

    // controller
    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .i_count  (count),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    // datapath
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_score     (i_score),
        .i_tag       (i_tag),
        .o_stat      (stat),
        .o_count     (count),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_score (o_out_score),
        .o_out_tag   (o_out_tag),
        .o_last      (o_last)
    );

endmodule

>>> rtl/spq_checker.sv
// spq_checker: port-level checks of the sorted priority queue, bound to the
// top level; depends on spq_pkg
module spq_port_checks import spq_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [1:0]                i_opcode,
    input logic                      o_valid,
    input logic [1:0]                o_status,
    input logic signed [SCORE_W-1:0] o_out_score,
    input logic [TAG_W-1:0]          o_out_tag,
    input logic                      o_last
);

    // every known command gets a beat on the next cycle
    a_known_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_INSERT || i_opcode == OP_REMOVE ||
                            i_opcode == OP_LIST)) |=> o_valid)
        else $error("command beat gave no result");

    // unused opcode gives nothing
    a_unused_cmd_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(i_opcode == OP_INSERT || i_opcode == OP_REMOVE ||
                             i_opcode == OP_LIST)) |=> !o_valid)
        else $error("unused opcode produced a result");

    // while a list walk runs, a non-final beat is out every cycle
    a_busy_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_valid && !o_last))
        else $error("list walk without a streaming beat");

    // a list stream never breaks before its last beat
    a_stream_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("list stream broke before last beat");

    // error beats are single, final and carry no entry
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_last && o_out_score == '0 && o_out_tag == '0))
        else $error("malformed empty/full result");

endmodule

bind sorted_priority_queue spq_port_checks u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_opcode    (i_opcode),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_out_score (o_out_score),
    .o_out_tag   (o_out_tag),
    .o_last      (o_last)
);

>>> dv/spq_checker.sv
`timescale 1ns / 100ps
// spq_checker: watches the command and result channels of sorted_priority_queue,
// keeps its own sorted copy of the queue, predicts every result beat and compares
// depends on spq_pkg
module spq_checker import spq_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [1:0]                i_opcode,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [TAG_W-1:0]          i_tag,
    input  logic                      i_valid,
    input  logic [1:0]                i_status,
    input  logic signed [SCORE_W-1:0] i_out_score,
    input  logic [TAG_W-1:0]          i_out_tag,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_beats
);

    typedef struct packed {
        logic [1:0]                status;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic                      last;
    } t_beat;

    // shadow copy of the queue, head at index 0
    logic signed [SCORE_W-1:0] held_scores [CAPACITY];
    logic [TAG_W-1:0]          held_tags [CAPACITY];
    int                        held_count = 0;

    // result beats predicted but not yet seen, oldest first
    t_beat due_beats [$];
    int    failures = 0;
    int    beats_seen = 0;

    function automatic t_beat make_beat(input logic [1:0] st,
                                        input logic signed [SCORE_W-1:0] sc,
                                        input logic [TAG_W-1:0] tg,
                                        input logic lst);
        t_beat b;
        b.status = st;
        b.score  = sc;
        b.tag    = tg;
        b.last   = lst;
        return b;
    endfunction

    // apply one accepted command to the shadow queue and queue up its beats
    task automatic queue_step(input logic [1:0] op,
                              input logic signed [SCORE_W-1:0] sc,
                              input logic [TAG_W-1:0] tg);
        int pos;
        int i;
        case (op)
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    due_beats.push_back(make_beat(ST_FULL, '0, '0, 1'b1));
                end else begin
                    // a tie with the head lands right after it, other ties go in front
                    if (held_count == 0 || held_scores[0] < sc) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < held_count && held_scores[pos] > sc)
                            pos++;
                    end
                    for (i = held_count; i > pos; i--) begin
                        held_scores[i] = held_scores[i-1];
                        held_tags[i]   = held_tags[i-1];
                    end
                    held_scores[pos] = sc;
                    held_tags[pos]   = tg;
                    held_count++;
                    due_beats.push_back(make_beat(ST_OK, '0, '0, 1'b1));
                end
            end
            OP_REMOVE: begin
                if (held_count == 0) begin
                    due_beats.push_back(make_beat(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    due_beats.push_back(make_beat(ST_OK, held_scores[0], held_tags[0], 1'b1));
                    for (i = 1; i < held_count; i++) begin
                        held_scores[i-1] = held_scores[i];
                        held_tags[i-1]   = held_tags[i];
                    end
                    held_count--;
                end
            end
            OP_LIST: begin
                if (held_count == 0) begin
                    due_beats.push_back(make_beat(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (i = 0; i < held_count; i++)
                        due_beats.push_back(make_beat(ST_OK, held_scores[i], held_tags[i],
                                                      i == held_count - 1));
                end
            end
            default: ;
        endcase
    endtask

    // compare on every rising edge: result side first, it belongs to earlier commands
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (!i_rst_n) begin
            held_count = 0;
            due_beats.delete();
        end else begin
            if (i_valid) begin
                got = make_beat(i_status, i_out_score, i_out_tag, i_last);
                beats_seen++;
                if (due_beats.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: unexpected result beat status=%0d score=%0d tag=%h last=%0b",
                                 $realtime, got.status, got.score, got.tag, got.last);
                    failures++;
                end else begin
                    want = due_beats.pop_front();
                    if (got !== want) begin
                        if (failures < 10) begin
                            $display("%0t: beat mismatch exp status=%0d score=%0d tag=%h last=%0b",
                                     $realtime, want.status, want.score, want.tag, want.last);
                            $display("    got status=%0d score=%0d tag=%h last=%0b",
                                     got.status, got.score, got.tag, got.last);
                        end
                        failures++;
                    end
                end
            end
            if (i_start && !i_busy)
                queue_step(i_opcode, i_score, i_tag);
        end
        o_fail_count <= failures;
        o_pending    <= due_beats.size();
        o_beats      <= beats_seen;
    end

endmodule

>>> dv/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// sorted_priority_queue_test: drives command beats into sorted_priority_queue
// and gives the verdict; checking is done by spq_checker, depends on spq_pkg
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int          CAPACITY   = DEFAULT_CAPACITY;
    localparam int          CYCLE_CAP  = 400000;
    localparam int          RAND_ITEMS = 350;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam logic signed [SCORE_W-1:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [SCORE_W-1:0] S_MIN = 32'sh80000000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_opcode = OP_INSERT;
    logic signed [SCORE_W-1:0] i_score = '0;
    logic [TAG_W-1:0]          i_tag = '0;
    logic                      o_valid;
    logic [1:0]                o_status;
    logic signed [SCORE_W-1:0] o_out_score;
    logic [TAG_W-1:0]          o_out_tag;
    logic                      o_last;

    int fail_count;
    int pending;
    int beats;
    int cycles = 0;
    int n_insert = 0;
    int n_remove = 0;
    int n_list = 0;
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    sorted_priority_queue #(.CAPACITY(CAPACITY)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_score     (i_score),
        .i_tag       (i_tag),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_score (o_out_score),
        .o_out_tag   (o_out_tag),
        .o_last      (o_last)
    );

    spq_checker #(.CAPACITY(CAPACITY)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_opcode     (i_opcode),
        .i_score      (i_score),
        .i_tag        (i_tag),
        .i_valid      (o_valid),
        .i_status     (o_status),
        .i_out_score  (o_out_score),
        .i_out_tag    (o_out_tag),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats      (beats)
    );

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("watchdog expired with %0d beats outstanding", pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // idle gap length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // scores biased toward ties and extremes
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed(32'($urandom_range(0, 6))) - 32'sd3;
        if (r < 55) begin
            case ($urandom_range(0, 5))
                0: return S_MAX;
                1: return S_MIN;
                2: return S_MAX - 1;
                3: return S_MIN + 1;
                4: return -32'sd1;
                default: return '0;
            endcase
        end
        return $signed($urandom());
    endfunction

    // one command beat, called at a falling edge, returns at a falling edge
    task automatic send_cmd(input logic [1:0] op, input logic signed [SCORE_W-1:0] sc,
                            input logic [TAG_W-1:0] tg);
        int n;
        start    = 1'b1;
        i_opcode = op;
        i_score  = sc;
        i_tag    = tg;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
        case (op)
            OP_INSERT: n_insert++;
            OP_REMOVE: n_remove++;
            OP_LIST:   n_list++;
            default: ;
        endcase
        n = gap_len();
        if (n > 0) begin
            // idle with junk on the payload lines
            start    = 1'b0;
            i_opcode = 2'($urandom());
            i_score  = $signed($urandom());
            i_tag    = $urandom();
            repeat (n) @(negedge i_clk);
        end
    endtask

    initial begin
        int sent;
        int r;
        int ins_w;
        int rem_w;
        logic [1:0] op;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty cases, unused opcode, extremes, ties, full queue
        send_cmd(OP_REMOVE, '0, '0);
        send_cmd(OP_LIST, '0, '0);
        send_cmd(OP_UNUSED, S_MAX, 32'hffffffff);
        send_cmd(OP_INSERT, '0, 32'h00000000);
        send_cmd(OP_INSERT, S_MAX, 32'hffffffff);
        send_cmd(OP_INSERT, S_MIN, 32'h00000001);
        send_cmd(OP_INSERT, -32'sd1, 32'h80000000);
        send_cmd(OP_INSERT, S_MAX, 32'h5a5a5a5a);   // tie with head
        send_cmd(OP_INSERT, '0, 32'ha5a5a5a5);      // tie below head
        send_cmd(OP_LIST, '0, '0);
        send_cmd(OP_REMOVE, '0, '0);
        send_cmd(OP_INSERT, 32'sd5, 32'h11111111);
        send_cmd(OP_INSERT, 32'sd5, 32'h22222222);
        send_cmd(OP_INSERT, -32'sd5, 32'h33333333);
        send_cmd(OP_INSERT, 32'sd100, 32'h44444444);
        send_cmd(OP_INSERT, -32'sd100, 32'h55555555);
        send_cmd(OP_INSERT, 32'sd1, 32'h66666666);
        send_cmd(OP_INSERT, 32'sd1, 32'h77777777);
        send_cmd(OP_INSERT, S_MAX, 32'h88888888);
        send_cmd(OP_INSERT, S_MIN, 32'h99999999);
        send_cmd(OP_INSERT, 32'sd7, 32'hdeadbeef);
        send_cmd(OP_INSERT, 32'sd2, 32'h0f0f0f0f);   // queue now full
        send_cmd(OP_INSERT, S_MAX, 32'hcafef00d);    // dropped
        send_cmd(OP_LIST, '0, '0);
        send_cmd(OP_REMOVE, '0, '0);

        // random: alternate filling and draining phases, some with no gaps
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 40 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                if ((sent / 40) % 2 == 0) begin
                    ins_w = 65;
                    rem_w = 20;
                end else begin
                    ins_w = 20;
                    rem_w = 62;
                end
            end
            r = $urandom_range(0, 99);
            if (r < ins_w)
                op = OP_INSERT;
            else if (r < ins_w + rem_w)
                op = OP_REMOVE;
            else if (r < 97)
                op = OP_LIST;
            else
                op = OP_UNUSED;
            send_cmd(op, pick_score(), $urandom());
            if (op != OP_UNUSED)
                sent++;
        end
        start = 1'b0;

        // drain outstanding beats, then a short tail for stray ones
        while (pending != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("covered %0d inserts, %0d removes, %0d lists; %0d result beats compared",
                 n_insert, n_remove, n_list, beats);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/spq_checker.sv
dv/sorted_priority_queue_test.sv
